>>> rtl/core/assert_macros.svh
// Assertion macros shared by the centroid accumulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

>>> rtl/core/wca_pkg.sv
// Shared constants and controller/datapath interface types.
`default_nettype none

package wca_pkg;

  localparam int COORD_BITS    = 16;
  localparam int MASS_BITS     = 16;
  localparam int MASS_SUM_BITS = 48;
  localparam int PROD_BITS     = 32;
  localparam int OUT_BITS      = 24;
  localparam int IN_DATA_BITS  = 48;
  localparam int OUT_DATA_BITS = 48;
  localparam int OUT_USER_BITS = 2;

  // Bit positions inside the result tuser field.
  localparam int USER_ZERO_MASS = 0;
  localparam int USER_OVERFLOW  = 1;

  typedef struct packed {
    logic take;       // an input item is accepted this cycle
    logic div_start;  // load both dividers from the snapshot registers
    logic out_load;   // write the result into the output register
  } cmd_t;

  typedef struct packed {
    logic div_busy;   // dividers are still iterating
    logic out_busy;   // output register holds an item not yet taken
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/core/wca_div.sv
// Restoring divider, one quotient bit per cycle, with signed saturating result.
`default_nettype none

module wca_div #(
  parameter int ACC_BITS  = 64,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic [ACC_BITS-1:0]                   dividend,
  input  wire logic [wca_pkg::MASS_SUM_BITS-1:0]     divisor,
  output logic                                       busy,
  output logic [wca_pkg::OUT_BITS-1:0]               result
);

  localparam int QUO_BITS = ACC_BITS + FRAC_BITS;
  localparam int CNT_BITS = $clog2(QUO_BITS + 1);
  localparam int REM_BITS = wca_pkg::MASS_SUM_BITS;
  localparam int OUT_BITS = wca_pkg::OUT_BITS;

  logic [QUO_BITS-1:0] quo;
  logic [REM_BITS-1:0] rem;
  logic [REM_BITS-1:0] dsr;
  logic [CNT_BITS-1:0] cnt;
  logic                neg;

  logic [ACC_BITS-1:0] mag;
  logic [REM_BITS:0]   rem_sh;
  logic [REM_BITS:0]   rem_diff;
  logic                fits;
  logic                over;
  logic [OUT_BITS-1:0] lim;
  logic [OUT_BITS-1:0] sat_mag;

  assign mag      = dividend[ACC_BITS-1] ? (~dividend + ACC_BITS'(1)) : dividend;
  assign rem_sh   = {rem, quo[QUO_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, dsr};
  assign fits     = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_BITS'(QUO_BITS);
    end else if (busy) begin
      cnt <= cnt - CNT_BITS'(1);
      if (cnt == CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= QUO_BITS'(mag) << FRAC_BITS;
      rem <= '0;
      dsr <= divisor;
      neg <= dividend[ACC_BITS-1];
    end else if (busy) begin
      quo <= {quo[QUO_BITS-2:0], fits};
      rem <= fits ? rem_diff[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
    end
  end

  // Clamp the magnitude to what a 24-bit signed value can carry for this sign.
  assign lim     = neg ? (OUT_BITS'(1) << (OUT_BITS - 1))
                       : ((OUT_BITS'(1) << (OUT_BITS - 1)) - OUT_BITS'(1));
  assign over    = (|quo[QUO_BITS-1:OUT_BITS]) || (quo[OUT_BITS-1:0] > lim);
  assign sat_mag = over ? lim : quo[OUT_BITS-1:0];
  assign result  = neg ? (~sat_mag + OUT_BITS'(1)) : sat_mag;

endmodule

`default_nettype wire

>>> rtl/core/wca_dpath.sv
// Datapath: product stage, accumulators, snapshot, dividers and output register.
`default_nettype none
`include "assert_macros.svh"

module wca_dpath #(
  parameter int ACC_BITS  = 64,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire wca_pkg::cmd_t                        cmd,
  output wca_pkg::stat_t                            stat,
  input  wire logic [wca_pkg::IN_DATA_BITS-1:0]     s_tdata,
  input  wire logic                                 s_tlast,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [wca_pkg::OUT_DATA_BITS-1:0]         m_tdata,
  output logic [wca_pkg::OUT_USER_BITS-1:0]         m_tuser
);

  localparam int CB = wca_pkg::COORD_BITS;
  localparam int MB = wca_pkg::MASS_BITS;
  localparam int PB = wca_pkg::PROD_BITS;
  localparam int SB = wca_pkg::MASS_SUM_BITS;
  localparam int OB = wca_pkg::OUT_BITS;

  localparam int USER_ZERO_IDX = wca_pkg::USER_ZERO_MASS;
  localparam int USER_OVF_IDX  = wca_pkg::USER_OVERFLOW;

  // Input fields. A full-scale coordinate times a full-scale mass fits in PB
  // signed bits, so the products are formed at that width.
  logic signed [CB-1:0] x_in;
  logic signed [CB-1:0] y_in;
  logic signed [MB:0]   mass_s;
  logic signed [PB-1:0] mul_x;
  logic signed [PB-1:0] mul_y;

  assign x_in   = s_tdata[CB-1:0];
  assign y_in   = s_tdata[2*CB-1:CB];
  assign mass_s = {1'b0, s_tdata[2*CB+MB-1:2*CB]};
  assign mul_x  = x_in * mass_s;
  assign mul_y  = y_in * mass_s;

  // Product stage.
  logic                 pipe_v;
  logic                 pipe_last;
  logic signed [PB-1:0] prod_x;
  logic signed [PB-1:0] prod_y;
  logic [MB-1:0]        pmass;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_v    <= 1'b0;
      pipe_last <= 1'b0;
    end else begin
      pipe_v    <= cmd.take;
      pipe_last <= cmd.take && s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      prod_x <= mul_x;
      prod_y <= mul_y;
      pmass  <= s_tdata[2*CB+MB-1:2*CB];
    end
  end

  // Accumulators.
  logic [SB-1:0]              total_mass;
  logic [ACC_BITS-1:0]        moment_x;
  logic [ACC_BITS-1:0]        moment_y;
  logic                       overflow_seen;
  logic signed [ACC_BITS-1:0] ext_x;
  logic signed [ACC_BITS-1:0] ext_y;
  logic [ACC_BITS-1:0]        sum_x;
  logic [ACC_BITS-1:0]        sum_y;
  logic [SB:0]                sum_m;
  logic                       ovf_x;
  logic                       ovf_y;
  logic                       ovf_step;

  assign ext_x = prod_x;
  assign ext_y = prod_y;
  assign sum_x = moment_x + ext_x;
  assign sum_y = moment_y + ext_y;
  assign sum_m = {1'b0, total_mass} + (SB + 1)'(pmass);
  assign ovf_x = (moment_x[ACC_BITS-1] == ext_x[ACC_BITS-1]) &&
                 (sum_x[ACC_BITS-1] != moment_x[ACC_BITS-1]);
  assign ovf_y = (moment_y[ACC_BITS-1] == ext_y[ACC_BITS-1]) &&
                 (sum_y[ACC_BITS-1] != moment_y[ACC_BITS-1]);
  assign ovf_step = ovf_x || ovf_y || sum_m[SB];

  logic [ACC_BITS-1:0] snap_x;
  logic [ACC_BITS-1:0] snap_y;
  logic [SB-1:0]       snap_mass;
  logic                snap_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_mass    <= '0;
      moment_x      <= '0;
      moment_y      <= '0;
      overflow_seen <= 1'b0;
    end else if (pipe_v && pipe_last) begin
      total_mass    <= '0;
      moment_x      <= '0;
      moment_y      <= '0;
      overflow_seen <= 1'b0;
    end else if (pipe_v) begin
      total_mass    <= sum_m[SB-1:0];
      moment_x      <= sum_x;
      moment_y      <= sum_y;
      overflow_seen <= overflow_seen || ovf_step;
    end
  end

  // The set's final sums are frozen here while the dividers run.
  always_ff @(posedge clk) begin
    if (pipe_v && pipe_last) begin
      snap_x    <= sum_x;
      snap_y    <= sum_y;
      snap_mass <= sum_m[SB-1:0];
      snap_ovf  <= overflow_seen || ovf_step;
    end
  end

  logic          busy_x;
  logic          busy_y;
  logic [OB-1:0] res_x;
  logic [OB-1:0] res_y;

  wca_div #(
    .ACC_BITS  (ACC_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (snap_x),
    .divisor  (snap_mass),
    .busy     (busy_x),
    .result   (res_x)
  );

  wca_div #(
    .ACC_BITS  (ACC_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (snap_y),
    .divisor  (snap_mass),
    .busy     (busy_y),
    .result   (res_y)
  );

  // Output register.
  logic zero_m;

  assign zero_m = (snap_mass == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata                 <= zero_m ? '0 : {res_y, res_x};
      m_tuser[USER_ZERO_IDX]  <= zero_m;
      m_tuser[USER_OVF_IDX]   <= snap_ovf;
    end
  end

  assign stat.div_busy = busy_x || busy_y;
  assign stat.out_busy = m_tvalid && !m_tready;

  `ASSERT_NEXT(a_clear_after_last, pipe_v && pipe_last,
               total_mass == '0 && moment_x == '0 && moment_y == '0 && !overflow_seen)
  `ASSERT_IMPLIES(a_zero_mass_zero_data, m_tvalid && m_tuser[USER_ZERO_IDX],
                  m_tdata == '0)

endmodule

`default_nettype wire

>>> rtl/core/wca_ctrl.sv
// Controller: sequences accumulation, snapshot, division and result hand-off.
`default_nettype none
`include "assert_macros.svh"

module wca_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  input  wire logic           s_tlast,
  output logic                s_tready,
  input  wire wca_pkg::stat_t stat,
  output wca_pkg::cmd_t       cmd
);

  typedef enum logic [4:0] {
    ST_ACC   = 5'b00001,
    ST_SNAP  = 5'b00010,
    ST_START = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    cmd.take      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.out_load  = 1'b0;
    case (state)
      ST_ACC: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
        if (s_tvalid && s_tlast) begin
          state_next = ST_SNAP;
        end
      end
      ST_SNAP: begin
        state_next = ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (!stat.div_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_ACC;
        end
      end
      default: begin
        state_next = ST_ACC;
      end
    endcase
  end

  `ASSERT_NEXT(a_start_makes_busy, state == ST_START, stat.div_busy)
  `ASSERT_IMPLIES(a_emit_after_div, state == ST_EMIT, !stat.div_busy)

endmodule

`default_nettype wire

>>> rtl/core/weighted_centroid_accumulator.sv
// Top level of the weighted 2-D centroid accumulator.
// Throughput: one point item per cycle within a set; products and sums are pipelined.
// After a last item is accepted, its set passes through the snapshot registers, the
//   bit-serial restoring dividers and the output register before its result appears.
// No item is accepted while a set divides; a result may wait while the next set streams.
// Reset (rst, synchronous, active high) clears the accumulators, flags and control.
`default_nettype none

module weighted_centroid_accumulator #(
  parameter int ACC_BITS  = 64,  // width of the two moment accumulators, 32 to 64
  parameter int FRAC_BITS = 8    // fraction bits of the centroid results, 0 to 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Point items. s_tdata from bit 0 up: point_x[15:0], point_y[15:0],
  // point_mass[15:0]. s_tlast carries last_point.
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [wca_pkg::IN_DATA_BITS-1:0]     s_tdata,
  input  wire logic                                 s_tlast,
  // Result items. m_tdata from bit 0 up: centroid_x[23:0], centroid_y[23:0].
  // m_tuser from bit 0 up: zero_mass, sum_overflow.
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [wca_pkg::OUT_DATA_BITS-1:0]         m_tdata,
  output logic [wca_pkg::OUT_USER_BITS-1:0]         m_tuser
);

  // The controller only sees the handshake and two status bits; all arithmetic
  // lives in the datapath.
  wca_pkg::cmd_t  cmd;
  wca_pkg::stat_t stat;

  wca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Each accepted item is multiplied into a product register, then added into
  // the mass sum and the two moments in the following cycle. The last item of
  // a set is frozen into snapshot registers while the accumulators clear, and
  // two dividers then compute each moment over the mass sum with saturation.
  wca_dpath #(
    .ACC_BITS  (ACC_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
